// ===== hdl/tmp_pkg.sv =====
// ----------------------------------------------------------------------------
// tmp_pkg
// Shared types, widths and codes of the trapezoid motion profile core.
// ----------------------------------------------------------------------------
package tmp_pkg;

  localparam int TIME_BITS_DEF = 16;

  localparam int TICK_W     = 16;
  localparam int COORD_W    = 24;
  localparam int RATE_W     = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;
  localparam int DIST_W     = 25;

  // derived constant widths
  localparam int LEN_W  = 26;
  localparam int S1_W   = 32;
  localparam int CVA_W  = 33;
  localparam int B1_W   = 43;
  localparam int SEND_W = 34;
  localparam int QUO_W  = 67;

  localparam logic [RATE_W-1:0] RATE_RESET = 16'd256;

  typedef enum logic [1:0] {
    PH_ACCEL  = 2'd0,
    PH_CRUISE = 2'd1,
    PH_DECEL  = 2'd2,
    PH_DONE   = 2'd3
  } phase_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_START_X  = 3'd0,
    REG_START_Y  = 3'd1,
    REG_TARGET_X = 3'd2,
    REG_TARGET_Y = 3'd3,
    REG_CRUISE   = 3'd4,
    REG_ACCEL    = 3'd5,
    REG_DECEL    = 3'd6
  } reg_idx_t;

  typedef struct packed {
    logic [COORD_W-1:0] start_x;
    logic [COORD_W-1:0] start_y;
    logic [COORD_W-1:0] target_x;
    logic [COORD_W-1:0] target_y;
    logic [RATE_W-1:0]  cruise_speed;
    logic [RATE_W-1:0]  accel_rate;
    logic [RATE_W-1:0]  decel_rate;
  } cfg_t;

  // move constants, fixed between configuration writes
  typedef struct packed {
    logic [RATE_W-1:0] v;
    logic [RATE_W-1:0] a;
    logic [RATE_W-1:0] d;
    logic [LEN_W-1:0]  len;
    logic [S1_W-1:0]   s1;
    logic [CVA_W-1:0]  cva;     // ceil(v*v / a)
    logic [B1_W-1:0]   b1;      // v*v + s3*a
    logic [SEND_W-1:0] send;    // s1 + s2 + s3
    logic [QUO_W-1:0]  q;       // floor(256*total / m)
    logic              q_nz;    // remainder of q nonzero
    logic              short_move;
  } derived_t;

endpackage

// ===== hdl/tmp_setup.sv =====
// ----------------------------------------------------------------------------
// tmp_setup
// Sequencer that derives the move constants from the configuration: path
// length by a bit-pair square root, then three restoring divisions.
// ----------------------------------------------------------------------------
module tmp_setup (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             restart,
  input  tmp_pkg::cfg_t    cfg,
  output logic             busy,
  output tmp_pkg::derived_t drv
);

  localparam int ROOT_STEPS = 26;
  localparam int DIV_STEPS  = 67;
  localparam int CNT_W      = 7;

  typedef enum logic [11:0] {
    ST_IDLE = 12'b0000_0000_0001,
    ST_DIFF = 12'b0000_0000_0010,
    ST_SQX  = 12'b0000_0000_0100,
    ST_SQY  = 12'b0000_0000_1000,
    ST_ROOT = 12'b0000_0001_0000,
    ST_DIVA = 12'b0000_0010_0000,
    ST_DIVD = 12'b0000_0100_0000,
    ST_S3   = 12'b0000_1000_0000,
    ST_M1   = 12'b0001_0000_0000,
    ST_M2   = 12'b0010_0000_0000,
    ST_TOT  = 12'b0100_0000_0000,
    ST_DIVQ = 12'b1000_0000_0000
  } state_t;

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  logic [15:0] v_r, a_r, d_r;
  logic [24:0] ux_r, uy_r;
  logic [49:0] sqx_r;
  logic [31:0] vv_r;
  logic [51:0] rad_r;
  logic [25:0] root_r;
  logic [27:0] srem_r;
  logic [66:0] numq_r;
  logic [47:0] drem_r, den_r;
  logic [31:0] s1_r, s2_r;
  logic [32:0] cva_r;
  logic [25:0] s3_r;
  logic        shortm_r;
  logic [31:0] ad_r;
  logic [47:0] m_r, vva_r, vvd_r;
  logic [41:0] s3a_r;
  logic [57:0] s3ad_r;
  logic [42:0] b1_r;
  logic [33:0] send_r;
  logic [66:0] q_r;
  logic        q_nz_r;

  logic signed [24:0] dx, dy;
  logic [24:0] ux, uy;
  logic [49:0] uysq;
  logic [29:0] srem_sh, strial;
  logic        sfit;
  logic [27:0] srem_nxt;
  logic [25:0] root_nxt;
  logic [48:0] drem_sh;
  logic        dfit;
  logic [47:0] drem_nxt;
  logic [66:0] numq_nxt;
  logic [32:0] sum12;
  logic        shortm;
  logic [25:0] s3;
  logic [58:0] total;
  logic        root_last, div_last;

  always_comb begin
    dx = {cfg.target_x[23], cfg.target_x} - {cfg.start_x[23], cfg.start_x};
    dy = {cfg.target_y[23], cfg.target_y} - {cfg.start_y[23], cfg.start_y};
    ux = dx[24] ? (~dx + 25'd1) : dx;
    uy = dy[24] ? (~dy + 25'd1) : dy;
    uysq = uy_r * uy_r;
    // square root, two radicand bits a step
    srem_sh  = {srem_r, rad_r[51:50]};
    strial   = {2'b00, root_r, 2'b01};
    sfit     = srem_sh >= strial;
    srem_nxt = sfit ? 28'(srem_sh - strial) : 28'(srem_sh);
    root_nxt = {root_r[24:0], sfit};
    // restoring divide, one quotient bit a step
    drem_sh  = {drem_r, numq_r[66]};
    dfit     = drem_sh >= {1'b0, den_r};
    drem_nxt = dfit ? 48'(drem_sh - {1'b0, den_r}) : 48'(drem_sh);
    numq_nxt = {numq_r[65:0], dfit};
    sum12  = 33'(s1_r) + 33'(s2_r);
    shortm = 33'(root_r) < sum12;
    s3     = shortm ? 26'd0 : 26'(33'(root_r) - sum12);
    total  = 59'(vvd_r) + 59'(vva_r) + 59'(s3ad_r);
    root_last = cnt_r == CNT_W'(ROOT_STEPS - 1);
    div_last  = cnt_r == CNT_W'(DIV_STEPS - 1);
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r + CNT_W'(1);
    unique case (state_r)
      ST_IDLE: state_nxt = ST_IDLE;
      ST_DIFF: state_nxt = ST_SQX;
      ST_SQX:  state_nxt = ST_SQY;
      ST_SQY: begin
        state_nxt = ST_ROOT;
        cnt_nxt   = '0;
      end
      ST_ROOT: if (root_last) begin
        state_nxt = ST_DIVA;
        cnt_nxt   = '0;
      end
      ST_DIVA: if (div_last) begin
        state_nxt = ST_DIVD;
        cnt_nxt   = '0;
      end
      ST_DIVD: if (div_last) state_nxt = ST_S3;
      ST_S3:   state_nxt = ST_M1;
      ST_M1:   state_nxt = ST_M2;
      ST_M2:   state_nxt = ST_TOT;
      ST_TOT: begin
        state_nxt = ST_DIVQ;
        cnt_nxt   = '0;
      end
      ST_DIVQ: if (div_last) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
    if (restart) state_nxt = ST_DIFF;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_DIFF;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      ST_DIFF: begin
        v_r  <= (cfg.cruise_speed == 16'd0) ? 16'd1 : cfg.cruise_speed;
        a_r  <= (cfg.accel_rate == 16'd0) ? 16'd1 : cfg.accel_rate;
        d_r  <= (cfg.decel_rate == 16'd0) ? 16'd1 : cfg.decel_rate;
        ux_r <= ux;
        uy_r <= uy;
      end
      ST_SQX: begin
        sqx_r <= ux_r * ux_r;
        vv_r  <= v_r * v_r;
      end
      ST_SQY: begin
        rad_r  <= {1'b0, 51'(sqx_r) + 51'(uysq)};
        root_r <= '0;
        srem_r <= '0;
      end
      ST_ROOT: begin
        root_r <= root_nxt;
        srem_r <= srem_nxt;
        rad_r  <= {rad_r[49:0], 2'b00};
        if (root_last) begin
          numq_r <= 67'(vv_r);
          den_r  <= 48'(a_r);
          drem_r <= '0;
        end
      end
      ST_DIVA: begin
        if (div_last) begin
          s1_r   <= 32'(numq_nxt >> 1);
          cva_r  <= 33'(numq_nxt) + 33'(drem_nxt != 48'd0);
          numq_r <= 67'(vv_r);
          den_r  <= 48'(d_r);
          drem_r <= '0;
        end else begin
          numq_r <= numq_nxt;
          drem_r <= drem_nxt;
        end
      end
      ST_DIVD: begin
        numq_r <= numq_nxt;
        drem_r <= drem_nxt;
        if (div_last) s2_r <= 32'(numq_nxt >> 1);
      end
      ST_S3: begin
        s3_r     <= s3;
        shortm_r <= shortm;
        ad_r     <= a_r * d_r;
      end
      ST_M1: begin
        m_r    <= ad_r * v_r;
        s3a_r  <= s3_r * a_r;
        vva_r  <= vv_r * a_r;
        send_r <= 34'(sum12) + 34'(s3_r);
      end
      ST_M2: begin
        s3ad_r <= s3a_r * d_r;
        vvd_r  <= vv_r * d_r;
        b1_r   <= 43'(vv_r) + 43'(s3a_r);
      end
      ST_TOT: begin
        numq_r <= {total, 8'b0};
        den_r  <= m_r;
        drem_r <= '0;
      end
      ST_DIVQ: begin
        numq_r <= numq_nxt;
        drem_r <= drem_nxt;
        if (div_last) begin
          q_r    <= numq_nxt;
          q_nz_r <= drem_nxt != 48'd0;
        end
      end
      default: ;
    endcase
  end

  assign busy = state_r != ST_IDLE;

  always_comb begin
    drv.v          = v_r;
    drv.a          = a_r;
    drv.d          = d_r;
    drv.len        = root_r;
    drv.s1         = s1_r;
    drv.cva        = cva_r;
    drv.b1         = b1_r;
    drv.send       = send_r;
    drv.q          = q_r;
    drv.q_nz       = q_nz_r;
    drv.short_move = shortm_r;
  end

endmodule

// ===== hdl/trapezoid_motion_profile_core.sv =====
// ----------------------------------------------------------------------------
// trapezoid_motion_profile_core
// Distance travelled and phase along a trapezoidal velocity profile.
// ----------------------------------------------------------------------------
// One elapsed-time beat is taken per clock while busy is low, and its result
// appears as a one-cycle out_valid strobe at the end of the seven-stage
// multiply/compare pipeline, which cannot be held off. After reset and after
// every configuration write, busy stays high while the setup sequencer
// derives the path length (26-step square root) and three 67-step divisions;
// no beat is taken then.
module trapezoid_motion_profile_core #(
  parameter int TIME_BITS = tmp_pkg::TIME_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  output logic                               busy,
  input  logic [tmp_pkg::TICK_W-1:0]         in_elapsed_ticks,
  output logic                               out_valid,
  output logic [tmp_pkg::DIST_W-1:0]         out_travelled,
  output logic [1:0]                         out_phase,
  output logic                               out_short_move,
  input  logic                               cfg_we,
  input  logic [tmp_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [tmp_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  localparam int T_W    = (TIME_BITS < tmp_pkg::TICK_W) ? TIME_BITS : tmp_pkg::TICK_W;
  localparam int TA_W   = T_W + 16;
  localparam int TT_W   = 2 * T_W;
  localparam int TQ_W   = T_W + 8;
  localparam int TAV_W  = T_W + 32;
  localparam int ATT_W  = 2 * T_W + 16;
  localparam int D0_W   = ATT_W - 1;
  localparam int D1_W   = 35;
  localparam int RAW_W  = (D0_W > D1_W) ? D0_W : D1_W;
  localparam int CW     = 68;
  localparam int RQ_W   = 25;

  tmp_pkg::cfg_t     cfg_r;
  tmp_pkg::derived_t drv;
  logic              in_acc;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.start_x      <= '0;
      cfg_r.start_y      <= '0;
      cfg_r.target_x     <= '0;
      cfg_r.target_y     <= '0;
      cfg_r.cruise_speed <= tmp_pkg::RATE_RESET;
      cfg_r.accel_rate   <= tmp_pkg::RATE_RESET;
      cfg_r.decel_rate   <= tmp_pkg::RATE_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        tmp_pkg::REG_START_X:  cfg_r.start_x      <= cfg_wdata;
        tmp_pkg::REG_START_Y:  cfg_r.start_y      <= cfg_wdata;
        tmp_pkg::REG_TARGET_X: cfg_r.target_x     <= cfg_wdata;
        tmp_pkg::REG_TARGET_Y: cfg_r.target_y     <= cfg_wdata;
        tmp_pkg::REG_CRUISE:   cfg_r.cruise_speed <= cfg_wdata[15:0];
        tmp_pkg::REG_ACCEL:    cfg_r.accel_rate   <= cfg_wdata[15:0];
        tmp_pkg::REG_DECEL:    cfg_r.decel_rate   <= cfg_wdata[15:0];
        default: ;
      endcase
    end
  end

  tmp_setup u_setup (
    .clk     (clk),
    .rst_n   (rst_n),
    .restart (cfg_we),
    .cfg     (cfg_r),
    .busy    (busy),
    .drv     (drv)
  );

  assign in_acc = start && !busy;

  // pipeline valid bits
  logic v1_r, v2_r, v3_r, v4_r, v5_r, v6_r, out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0; v2_r <= 1'b0; v3_r <= 1'b0;
      v4_r <= 1'b0; v5_r <= 1'b0; v6_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      v1_r <= in_acc; v2_r <= v1_r; v3_r <= v2_r;
      v4_r <= v3_r;   v5_r <= v4_r; v6_r <= v5_r;
      out_valid_r <= v6_r;
    end
  end

  logic [T_W-1:0]   t1_r;
  logic [TA_W-1:0]  ta2_r, vt2_r;
  logic [TT_W-1:0]  tt2_r;
  logic [TQ_W-1:0]  tq2_r, tq3_r;
  logic             p0_3_r, p0_4_r, p0_5_r, p0_6_r;
  logic             p1_4_r, p1_5_r, p1_6_r;
  logic             p2_4_r, p2_5_r, p2_6_r;
  logic [TAV_W-1:0] tav3_r;
  logic [ATT_W-1:0] att3_r;
  logic [D0_W-1:0]  d0_4_r, d0_5_r, d0_6_r;
  logic [D1_W-1:0]  d1_3_r, d1_4_r, d1_5_r, d1_6_r;
  logic [RQ_W-1:0]  rq4_r;
  logic [47:0]      rqsq5_r;
  logic [30:0]      sub6_r;
  logic [tmp_pkg::DIST_W-1:0] travelled_r;
  tmp_pkg::phase_t  phase_r;
  logic             short_r;

  logic [49:0]      rqsq;
  logic [63:0]      dsq;
  logic             p0_c, p1_c, p2_c;
  logic [tmp_pkg::SEND_W-1:0] d2;
  tmp_pkg::phase_t  ph;
  logic [RAW_W-1:0] raw;
  logic [tmp_pkg::LEN_W-1:0] clamped;

  always_comb begin
    p0_c = ta2_r < TA_W'(drv.v);
    p1_c = CW'(tav3_r) < CW'(drv.b1);
    // beyond the end of decel when 256*t has reached 256*total/m
    p2_c = (CW'(tq3_r) < CW'(drv.q)) || ((CW'(tq3_r) == CW'(drv.q)) && drv.q_nz);
    rqsq = rq4_r * rq4_r;
    dsq  = rqsq5_r * drv.d;
    d2   = (drv.send >= tmp_pkg::SEND_W'(sub6_r)) ?
           drv.send - tmp_pkg::SEND_W'(sub6_r) : '0;
    priority if (p0_6_r) ph = tmp_pkg::PH_ACCEL;
    else if (p1_6_r)     ph = tmp_pkg::PH_CRUISE;
    else if (p2_6_r)     ph = tmp_pkg::PH_DECEL;
    else                 ph = tmp_pkg::PH_DONE;
    unique case (ph)
      tmp_pkg::PH_ACCEL:  raw = RAW_W'(d0_6_r);
      tmp_pkg::PH_CRUISE: raw = RAW_W'(d1_6_r);
      tmp_pkg::PH_DECEL:  raw = RAW_W'(d2);
      default:            raw = RAW_W'(drv.len);
    endcase
    clamped = (raw > RAW_W'(drv.len)) ? drv.len : raw[tmp_pkg::LEN_W-1:0];
  end

  always_ff @(posedge clk) begin
    // stage 1
    t1_r   <= in_elapsed_ticks[T_W-1:0];
    // stage 2
    ta2_r  <= t1_r * drv.a;
    vt2_r  <= t1_r * drv.v;
    tt2_r  <= t1_r * t1_r;
    tq2_r  <= {t1_r, 8'b0};
    // stage 3
    p0_3_r <= p0_c;
    tav3_r <= ta2_r * drv.v;
    att3_r <= tt2_r * drv.a;
    d1_3_r <= D1_W'(drv.s1) + D1_W'(vt2_r) - D1_W'(drv.cva);
    tq3_r  <= tq2_r;
    // stage 4: remaining decel time, 8 fraction bits
    p0_4_r <= p0_3_r;
    p1_4_r <= p1_c;
    p2_4_r <= p2_c;
    d0_4_r <= att3_r[ATT_W-1:1];
    d1_4_r <= d1_3_r;
    rq4_r  <= drv.q[RQ_W-1:0] - RQ_W'(tq3_r);
    // stage 5
    p0_5_r  <= p0_4_r;
    p1_5_r  <= p1_4_r;
    p2_5_r  <= p2_4_r;
    d0_5_r  <= d0_4_r;
    d1_5_r  <= d1_4_r;
    rqsq5_r <= rqsq[47:0];
    // stage 6
    p0_6_r <= p0_5_r;
    p1_6_r <= p1_5_r;
    p2_6_r <= p2_5_r;
    d0_6_r <= d0_5_r;
    d1_6_r <= d1_5_r;
    sub6_r <= dsq[47:17];
    // output beat
    travelled_r <= tmp_pkg::DIST_W'(clamped);
    phase_r     <= ph;
    short_r     <= drv.short_move;
  end

  assign out_valid      = out_valid_r;
  assign out_travelled  = travelled_r;
  assign out_phase      = phase_r;
  assign out_short_move = short_r;

endmodule

// ===== hdl/tmp_checker.sv =====
// ----------------------------------------------------------------------------
// tmp_checker
// Port-level checks of beat latency and setup busy behavior.
// ----------------------------------------------------------------------------
module tmp_checker (
  input logic clk,
  input logic rst_n,
  input logic start,
  input logic busy,
  input logic out_valid,
  input logic cfg_we
);

  localparam int LAT = 7;

  a_beat_out: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##LAT out_valid)
    else $error("accepted beat gave no result");

  a_no_extra: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, LAT))
    else $error("result without accepted beat");

  a_cfg_busy: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_we |=> busy)
    else $error("config write did not start setup");

  a_busy_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(busy) |-> ($past(cfg_we) || !$past(rst_n)))
    else $error("busy rose without config write");

endmodule

bind trapezoid_motion_profile_core tmp_checker u_chk (.*);
